@@ design/frg_pkg.sv @@
// Shared constants and sequencer state type for the fraction reducer.
package frg_pkg;

    localparam int WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REM,
        ST_DIVN,
        ST_DIVD,
        ST_DONE
    } frg_state_t;

endpackage

@@ design/frg_div.sv @@
// Iterative signed truncating divider, one quotient bit per cycle.
module frg_div
    import frg_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder,
    output logic             ovf
);

    localparam int CNT_W = $clog2(WIDTH);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dm_reg, dm_next;
    logic             na_reg, na_next;
    logic             nq_reg, nq_next;

    logic [WIDTH-1:0] am;
    logic [WIDTH-1:0] bm;
    logic [WIDTH:0]   trial;

    // Magnitudes; the minimum value maps to 2^(WIDTH-1) as unsigned.
    assign am = dividend[WIDTH-1] ? (~dividend + 1'b1) : dividend;
    assign bm = divisor[WIDTH-1] ? (~divisor + 1'b1) : divisor;

    assign trial = {rem_reg, quo_reg[WIDTH-1]} - {1'b0, dm_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dm_next   = dm_reg;
        na_next   = na_reg;
        nq_next   = nq_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(WIDTH - 1);
            quo_next  = am;
            rem_next  = '0;
            dm_next   = bm;
            na_next   = dividend[WIDTH-1];
            nq_next   = dividend[WIDTH-1] ^ divisor[WIDTH-1];
        end else if (busy_reg) begin
            // Restoring step: keep the difference when it does not go negative.
            if (!trial[WIDTH]) begin
                rem_next = trial[WIDTH-1:0];
                quo_next = {quo_reg[WIDTH-2:0], 1'b1};
            end else begin
                rem_next = {rem_reg[WIDTH-2:0], quo_reg[WIDTH-1]};
                quo_next = {quo_reg[WIDTH-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg <= cnt_next;
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dm_reg  <= dm_next;
        na_reg  <= na_next;
        nq_reg  <= nq_next;
    end

    assign done      = done_reg;
    assign quotient  = nq_reg ? (~quo_reg + 1'b1) : quo_reg;
    assign remainder = na_reg ? (~rem_reg + 1'b1) : rem_reg;
    // A positive quotient of 2^(WIDTH-1) does not fit.
    assign ovf       = !nq_reg && quo_reg[WIDTH-1];

endmodule

@@ design/fraction_reduce_gcd.sv @@
// Fraction reducer: Euclid's gcd and two final divisions on one shared divider.
// A zero denominator bypasses the divider; otherwise the divider runs Euclid's remainder steps,
//   then the numerator and denominator divisions, before the result beat.
// Throughput: one item at a time; the next input beat is taken only once the sequencer is idle;
//   every step is one pass of the divider.
// Reset: aresetn low at a clock edge idles the sequencer and clears m_tvalid.
module fraction_reduce_gcd
    import frg_pkg::*;
#(
    parameter int WIDTH = WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // numerator, denominator
    input  logic [((2*WIDTH+7)/8)*8-1:0]        s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // reduced_numerator, reduced_denominator, common_divisor
    output logic [((3*WIDTH+7)/8)*8-1:0]        m_tdata,
    // overflow
    output logic                                m_tuser
);

    localparam int M_W = ((3*WIDTH+7)/8)*8;

    frg_state_t state_reg, state_next;

    logic [WIDTH-1:0] num_reg, num_next;
    logic [WIDTH-1:0] den_reg, den_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic [WIDTH-1:0] rn_reg, rn_next;
    logic [WIDTH-1:0] rd_reg, rd_next;
    logic             ovf_reg, ovf_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic [M_W-1:0]   m_tdata_reg, m_tdata_next;
    logic             m_tuser_reg, m_tuser_next;

    logic [WIDTH-1:0] s_num;
    logic [WIDTH-1:0] s_den;
    logic             s_beat;
    logic             out_free;

    logic             div_start;
    logic [WIDTH-1:0] div_a;
    logic [WIDTH-1:0] div_b;
    logic             div_done;
    logic [WIDTH-1:0] div_q;
    logic [WIDTH-1:0] div_r;
    logic             div_ovf;

    assign s_num    = s_tdata[WIDTH-1:0];
    assign s_den    = s_tdata[2*WIDTH-1:WIDTH];
    assign s_beat   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    frg_div #(.WIDTH(WIDTH)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_r),
        .ovf       (div_ovf)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = (s_den == '0) ? ST_DONE : ST_REM;
                end
            end
            ST_REM: begin
                if (div_done && (div_r == '0)) begin
                    state_next = ST_DIVN;
                end
            end
            ST_DIVN: begin
                if (div_done) begin
                    state_next = ST_DIVD;
                end
            end
            ST_DIVD: begin
                if (div_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake and divider operand select
    always_comb begin
        s_tready  = 1'b0;
        div_start = 1'b0;
        div_a     = b_reg;
        div_b     = div_r;
        case (state_reg)
            ST_IDLE: begin
                s_tready  = 1'b1;
                div_start = s_tvalid && (s_den != '0);
                div_a     = s_num;
                div_b     = s_den;
            end
            ST_REM: begin
                div_start = div_done;
                if (div_r == '0) begin
                    // gcd found in b: divide the numerator by it
                    div_a = num_reg;
                    div_b = b_reg;
                end else begin
                    div_a = b_reg;
                    div_b = div_r;
                end
            end
            ST_DIVN: begin
                div_start = div_done;
                div_a     = den_reg;
                div_b     = b_reg;
            end
            default: begin
                s_tready  = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    // Datapath registers
    always_comb begin
        num_next      = num_reg;
        den_next      = den_reg;
        b_next        = b_reg;
        rn_next       = rn_reg;
        rd_next       = rd_reg;
        ovf_next      = ovf_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE: begin
                if (s_beat) begin
                    num_next = s_num;
                    den_next = s_den;
                    b_next   = s_den;
                    // Zero denominator passes through with a zero divisor.
                    rn_next  = s_num;
                    rd_next  = '0;
                    ovf_next = 1'b0;
                end
            end
            ST_REM: begin
                if (div_done && (div_r != '0)) begin
                    b_next = div_r;
                end
            end
            ST_DIVN: begin
                if (div_done) begin
                    rn_next  = div_q;
                    ovf_next = div_ovf;
                end
            end
            ST_DIVD: begin
                if (div_done) begin
                    rd_next  = div_q;
                    ovf_next = ovf_reg || div_ovf;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = M_W'({b_reg, rd_reg, rn_reg});
                    m_tuser_next  = ovf_reg;
                    if (den_reg == '0) begin
                        m_tdata_next = M_W'({{WIDTH{1'b0}}, {WIDTH{1'b0}}, rn_reg});
                    end
                end
            end
            default: begin
                m_tvalid_next = m_tvalid_reg && !m_tready;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        num_reg     <= num_next;
        den_reg     <= den_next;
        b_reg       <= b_next;
        rn_reg      <= rn_next;
        rd_reg      <= rd_next;
        ovf_reg     <= ovf_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The divider only reports back while the sequencer waits on it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == ST_REM || state_reg == ST_DIVN || state_reg == ST_DIVD))
        else $error("divider finished outside a divide state");

    // The gcd must divide the numerator exactly.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVN && div_done) |-> (div_r == '0))
        else $error("numerator not divisible by gcd");

    // The gcd must divide the denominator exactly.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIVD && div_done) |-> (div_r == '0))
        else $error("denominator not divisible by gcd");

    // An accepted beat always leaves idle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_beat |=> (state_reg != ST_IDLE))
        else $error("sequencer stayed idle after input beat");

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// Testbench for the fraction reducer: directed and random fractions checked against a gcd model.
module tb_top;
    import frg_pkg::*;

    localparam int W           = WIDTH_DEF;
    localparam int SW          = ((2*W+7)/8)*8;
    localparam int MW          = ((3*W+7)/8)*8;
    localparam int HOLD_CYCLES = 4000;
    localparam int DRAIN_LIMIT = 100000;
    localparam int TAIL_CYCLES = 2000;

    localparam logic signed [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};
    localparam logic signed [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};

    typedef struct packed {
        logic [W-1:0] quot_num;
        logic [W-1:0] quot_den;
        logic [W-1:0] divisor;
        logic         wrapped;
    } reduced_t;

    logic          aclk     = 1'b0;
    logic          aresetn  = 1'b0;
    logic          s_tvalid = 1'b0;
    logic          s_tready;
    logic [SW-1:0] s_tdata  = '0;  // numerator, denominator
    logic          m_tvalid;
    logic          m_tready = 1'b0;
    logic [MW-1:0] m_tdata;        // reduced_numerator, reduced_denominator, common_divisor
    logic          m_tuser;        // overflow

    reduced_t pending_fracs[$];
    int       bad_results = 0;
    bit       quiet       = 1'b0;
    int       hold_req    = 0;
    int       hold_ack    = 0;
    int       rx_wait     = 0;

    logic signed [W-1:0] corner_vals[5] = '{MIN_VAL, MAX_VAL, -1, 0, 1};

    fraction_reduce_gcd #(.WIDTH(W)) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #5 aclk = ~aclk;

    // Euclid with truncating remainder; the last nonzero value keeps its sign.
    function automatic reduced_t reduce_fraction(logic signed [W-1:0] num,
                                                 logic signed [W-1:0] den);
        longint   a, b, r, qn, qd;
        reduced_t res;
        if (den == 0) begin
            res.quot_num = num;
            res.quot_den = '0;
            res.divisor  = '0;
            res.wrapped  = 1'b0;
            return res;
        end
        a = num;
        b = den;
        while (b != 0) begin
            r = a % b;
            a = b;
            b = r;
        end
        qn = num / a;
        qd = den / a;
        res.quot_num = qn[W-1:0];
        res.quot_den = qd[W-1:0];
        res.divisor  = a[W-1:0];
        res.wrapped  = (qn > longint'(MAX_VAL)) || (qd > longint'(MAX_VAL));
        return res;
    endfunction

    function automatic int pick_gap();
        int roll;
        if (quiet)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 90)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [W-1:0] any_operand();
        if ($urandom_range(0, 9) == 0)
            return corner_vals[$urandom_range(0, 4)];
        return $urandom;
    endfunction

    task automatic send_fraction(input logic signed [W-1:0] num,
                                 input logic signed [W-1:0] den);
        int gap;
        s_tdata  <= {den, num};
        s_tvalid <= 1'b1;
        do
            @(posedge aclk);
        while (!s_tready);
        pending_fracs.push_back(reduce_fraction(num, den));
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_fracs.size() != 0)
            @(posedge aclk);
    endtask

    task automatic test_directed();
        quiet = 1'b1;
        send_fraction(0, 0);
        send_fraction(5, 0);
        send_fraction(MIN_VAL, 0);
        send_fraction(MAX_VAL, 0);
        send_fraction(-1, 0);
        send_fraction(0, 7);
        send_fraction(0, MIN_VAL);
        send_fraction(12, 18);
        send_fraction(-12, 18);
        send_fraction(12, -18);
        send_fraction(-12, -18);
        send_fraction(MIN_VAL, -1);
        send_fraction(-1, MIN_VAL);
        send_fraction(MIN_VAL, MIN_VAL);
        send_fraction(MAX_VAL, MAX_VAL);
        send_fraction(MAX_VAL, MIN_VAL);
        send_fraction(MIN_VAL, MAX_VAL);
        send_fraction(MIN_VAL, 2);
        send_fraction(1, 1);
        send_fraction(-1, -1);
        send_fraction(7, 1);
        // consecutive Fibonacci numbers take the most remainder steps
        send_fraction(1836311903, 1134903170);
        send_fraction(-1134903170, 1836311903);
        quiet = 1'b0;
    endtask

    task automatic test_full_range();
        repeat (450) send_fraction(any_operand(), any_operand());
    endtask

    task automatic test_shared_factor();
        logic signed [W-1:0] factor, num, den;
        repeat (700) begin
            factor = $urandom_range(1, 4095);
            num    = factor * $urandom_range(0, 65535);
            den    = factor * $urandom_range(1, 65535);
            if ($urandom_range(0, 1))
                num = -num;
            if ($urandom_range(0, 1))
                den = -den;
            if ($urandom_range(0, 19) == 0)
                den = 0;
            else if ($urandom_range(0, 19) == 0)
                num = corner_vals[$urandom_range(0, 4)];
            send_fraction(num, den);
        end
    endtask

    // Stall the result side long enough that the input stalls behind it.
    task automatic test_output_hold();
        hold_req <= hold_req + 1;
        repeat (40) send_fraction(any_operand(), $urandom_range(1, 1000));
    endtask

    task automatic test_drain_pause();
        repeat (20) send_fraction(any_operand(), any_operand());
        wait_drained();
        repeat (20) send_fraction($urandom_range(0, 255), $urandom_range(0, 255));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_ack != hold_req) begin
            hold_ack = hold_req;
            rx_wait  = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else if (rx_wait > 0) begin
            rx_wait--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 4) == 0)
                rx_wait = pick_gap();
        end
    end

    always @(posedge aclk) begin
        reduced_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.quot_num = m_tdata[W-1:0];
            got.quot_den = m_tdata[2*W-1:W];
            got.divisor  = m_tdata[3*W-1:2*W];
            got.wrapped  = m_tuser;
            if (pending_fracs.size() == 0) begin
                bad_results++;
                if (bad_results <= 10)
                    $display("unexpected result beat: num %0d den %0d gcd %0d ovf %0b",
                             $signed(got.quot_num), $signed(got.quot_den),
                             $signed(got.divisor), got.wrapped);
            end else begin
                want = pending_fracs.pop_front();
                if (got !== want) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("mismatch: expected num %0d den %0d gcd %0d ovf %0b,",
                                 $signed(want.quot_num), $signed(want.quot_den),
                                 $signed(want.divisor), want.wrapped,
                                 " got num %0d den %0d gcd %0d ovf %0b",
                                 $signed(got.quot_num), $signed(got.quot_den),
                                 $signed(got.divisor), got.wrapped);
                end
            end
        end
    end

    initial begin
        int waited;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_full_range();
        test_shared_factor();
        test_output_hold();
        test_drain_pause();
        s_tvalid <= 1'b0;
        waited = 0;
        while (pending_fracs.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (bad_results == 0 && pending_fracs.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        #200_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
design/frg_pkg.sv
design/frg_div.sv
design/fraction_reduce_gcd.sv
tb/tb_top.sv
